// ===== design/pcosd_pkg.sv =====
// ============================================================================
// pcosd_pkg
// Shared types and constants of the palette / crop / OSD pixel stage.
// ============================================================================
`default_nettype none

package pcosd_pkg;

    // Request codes on the input channel
    typedef enum logic [1:0] {
        REQ_PAL_WRITE = 2'd0,
        REQ_VOLUME    = 2'd1,
        REQ_FRAME     = 2'd2,
        REQ_PIXEL     = 2'd3
    } req_type_t;

    // Kind of work handed from the front to the back
    typedef enum logic {
        CMD_PAL_WRITE = 1'b0,
        CMD_PIXEL     = 1'b1
    } cmd_kind_t;

    // Overlay decision made by the front for one pixel
    typedef enum logic [1:0] {
        OVL_NONE  = 2'd0,
        OVL_WHITE = 2'd1,
        OVL_GREEN = 2'd2,
        OVL_BLACK = 2'd3
    } ovl_mode_t;

    // Colors, RGB565
    localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [15:0] COLOR_GREEN = 16'h07E0;
    localparam logic [15:0] COLOR_BLACK = 16'h0000;

    localparam logic [7:0] HOLD_RESET = 8'd45;
    localparam logic [6:0] VOL_MAX    = 7'd100;
    localparam int         PCT_FULL   = 100;
    localparam int         BAR_MARGIN = 10;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Front-to-back command
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  addr;
        logic [15:0] wr_color;
        logic [7:0]  panel_x;
        logic [8:0]  panel_row;
        ovl_mode_t   ovl;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [7:0]  panel_x;
        logic [8:0]  panel_row;
        logic [15:0] pixel_color;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/pcosd_fifo.sv =====
// ============================================================================
// pcosd_fifo
// Small synchronous queue, register storage, head shown combinationally.
// ============================================================================
`default_nettype none

module pcosd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [WIDTH-1:0]             wr_data,
    input  wire logic                         rd_en,
    output logic [WIDTH-1:0]                  rd_data,
    output logic                              full,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/pcosd_front.sv =====
// ============================================================================
// pcosd_front
// Accepts requests, keeps frame / volume / overlay state and turns palette
// writes and kept pixels into commands for the back end.
// ============================================================================
`default_nettype none

module pcosd_front #(
    parameter int CROP_LEFT  = 8,
    parameter int OUT_WIDTH  = 240,
    parameter int OUT_HEIGHT = 240,
    parameter int PANEL_TOP  = 40,
    parameter int BAR_HEIGHT = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              push,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        src_x,
    input  wire logic [7:0]        src_y,
    input  wire logic [7:0]        pixel_index,
    input  wire logic [15:0]       palette_color,
    input  wire logic signed [7:0] volume_percent,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    // command queue
    input  wire logic              q_full,
    output logic                   q_push,
    output pcosd_pkg::cmd_t        q_cmd
);

    localparam logic [9:0] X_LO      = 10'(CROP_LEFT);
    localparam logic [9:0] X_HI      = 10'(CROP_LEFT + OUT_WIDTH);
    localparam logic [8:0] Y_END     = 9'(OUT_HEIGHT);
    localparam logic [8:0] Y_BAR     = 9'(OUT_HEIGHT - BAR_HEIGHT);
    localparam logic [8:0] Y_BAR_END = 9'(OUT_HEIGHT - 1);
    localparam logic [8:0] BX_LO     = 9'(pcosd_pkg::BAR_MARGIN);
    localparam logic [8:0] BX_HI     = 9'(OUT_WIDTH - pcosd_pkg::BAR_MARGIN);
    localparam logic [8:0] BX_LAST   = 9'(OUT_WIDTH - pcosd_pkg::BAR_MARGIN - 1);
    localparam int         FILL_SPAN = OUT_WIDTH - 2 * pcosd_pkg::BAR_MARGIN - 2;
    localparam logic [15:0] FILL_OFS =
        16'(pcosd_pkg::PCT_FULL * (pcosd_pkg::BAR_MARGIN + 1));

    logic [7:0] hold_reg,      hold_next;
    logic [6:0] vol_reg,       vol_next;
    logic [7:0] countdown_reg, countdown_next;
    logic       parity_reg,    parity_next;
    logic       keep_reg,      keep_next;
    logic       ovl_on_reg,    ovl_on_next;

    logic       accept;
    logic [9:0] sx_w;
    logic [8:0] sy_w;
    logic [7:0] px;
    logic [8:0] px_w;
    logic       in_window;
    logic       in_bar_rows;
    logic       in_bar_cols;
    logic       on_border;
    logic [15:0] fill_lhs;
    logic [15:0] fill_rhs;
    logic       green;
    pcosd_pkg::ovl_mode_t ovl;

    assign accept = push && !q_full;

    // Pixel geometry
    assign sx_w      = {2'b00, src_x};
    assign sy_w      = {1'b0, src_y};
    assign px        = 8'(sx_w - X_LO);
    assign px_w      = {1'b0, px};
    assign in_window = (sx_w >= X_LO) && (sx_w < X_HI) && (sy_w < Y_END);

    // Overlay bar: border, fill by 100*(x-11) <= span*vol
    assign in_bar_rows = ovl_on_reg && (sy_w >= Y_BAR);
    assign in_bar_cols = (px_w >= BX_LO) && (px_w < BX_HI);
    assign on_border   = (px_w == BX_LO) || (px_w == BX_LAST)
                      || (sy_w == Y_BAR) || (sy_w == Y_BAR_END);
    assign fill_lhs    = 16'(px) * 16'(pcosd_pkg::PCT_FULL);
    assign fill_rhs    = 16'(vol_reg) * 16'(FILL_SPAN) + FILL_OFS;
    assign green       = (vol_reg != '0) && (fill_lhs <= fill_rhs);

    always_comb
    begin
        if (!(in_bar_rows && in_bar_cols))
        begin
            ovl = pcosd_pkg::OVL_NONE;
        end
        else if (on_border)
        begin
            ovl = pcosd_pkg::OVL_WHITE;
        end
        else if (green)
        begin
            ovl = pcosd_pkg::OVL_GREEN;
        end
        else
        begin
            ovl = pcosd_pkg::OVL_BLACK;
        end
    end

    // Classification and state update
    always_comb
    begin
        hold_next      = cfg_we ? cfg_wdata : hold_reg;
        vol_next       = vol_reg;
        countdown_next = countdown_reg;
        parity_next    = parity_reg;
        keep_next      = keep_reg;
        ovl_on_next    = ovl_on_reg;
        q_push         = 1'b0;

        q_cmd.kind      = pcosd_pkg::CMD_PIXEL;
        q_cmd.addr      = pixel_index;
        q_cmd.wr_color  = palette_color;
        q_cmd.panel_x   = px;
        q_cmd.panel_row = 9'(sy_w + 9'(PANEL_TOP));
        q_cmd.ovl       = ovl;

        if (accept)
        begin
            case (pcosd_pkg::req_type_t'(req_type))
                pcosd_pkg::REQ_PAL_WRITE:
                begin
                    q_cmd.kind = pcosd_pkg::CMD_PAL_WRITE;
                    q_push     = 1'b1;
                end
                pcosd_pkg::REQ_VOLUME:
                begin
                    if (volume_percent[7])
                    begin
                        vol_next = '0;
                    end
                    else if (volume_percent[6:0] > pcosd_pkg::VOL_MAX)
                    begin
                        vol_next = pcosd_pkg::VOL_MAX;
                    end
                    else
                    begin
                        vol_next = volume_percent[6:0];
                    end
                    countdown_next = hold_reg;
                end
                pcosd_pkg::REQ_FRAME:
                begin
                    parity_next = !parity_reg;
                    keep_next   = parity_reg;
                    if (parity_reg && (countdown_reg != '0))
                    begin
                        ovl_on_next    = 1'b1;
                        countdown_next = countdown_reg - 1'b1;
                    end
                    else
                    begin
                        ovl_on_next = 1'b0;
                    end
                end
                pcosd_pkg::REQ_PIXEL:
                begin
                    q_push = keep_reg && in_window;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= pcosd_pkg::HOLD_RESET;
            vol_reg       <= '0;
            countdown_reg <= '0;
            parity_reg    <= 1'b0;
            keep_reg      <= 1'b0;
            ovl_on_reg    <= 1'b0;
        end
        else
        begin
            hold_reg      <= hold_next;
            vol_reg       <= vol_next;
            countdown_reg <= countdown_next;
            parity_reg    <= parity_next;
            keep_reg      <= keep_next;
            ovl_on_reg    <= ovl_on_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/pcosd_back.sv =====
// ============================================================================
// pcosd_back
// Executes commands: palette RAM writes and reads, overlay color select,
// and the result queue.
// ============================================================================
`default_nettype none

module pcosd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command queue
    input  wire logic              q_empty,
    input  wire pcosd_pkg::cmd_t   q_cmd,
    output logic                   q_pop,
    // result channel
    input  wire logic              pop,
    output logic                   empty,
    output logic [7:0]             panel_x,
    output logic [8:0]             panel_row,
    output logic [15:0]            pixel_color
);

    localparam int OUT_CNT_W = $clog2(pcosd_pkg::OUT_DEPTH + 1);
    localparam int OUT_W     = $bits(pcosd_pkg::out_item_t);

    logic [15:0] pal_mem [256];
    logic [15:0] rdata_reg;

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_x_reg;
    logic [8:0]           s1_row_reg;
    pcosd_pkg::ovl_mode_t s1_ovl_reg;

    logic [OUT_CNT_W-1:0] out_count;
    logic [OUT_CNT_W:0]   out_used;
    logic                 out_full;
    logic                 do_write;
    logic                 do_read;
    pcosd_pkg::out_item_t s1_item;
    pcosd_pkg::out_item_t head_item;
    logic [OUT_W-1:0]     head_bits;

    // Issue only when the result queue has room for the item in flight too
    assign out_used = {1'b0, out_count} + (OUT_CNT_W + 1)'(s1_valid_reg);
    assign q_pop    = !q_empty && (out_used < (OUT_CNT_W + 1)'(pcosd_pkg::OUT_DEPTH));
    assign do_write = q_pop && (q_cmd.kind == pcosd_pkg::CMD_PAL_WRITE);
    assign do_read  = q_pop && (q_cmd.kind == pcosd_pkg::CMD_PIXEL);
    assign s1_valid_next = do_read;

    // Palette RAM, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            pal_mem[q_cmd.addr] <= q_cmd.wr_color;
        end
        if (do_read)
        begin
            rdata_reg  <= pal_mem[q_cmd.addr];
            s1_x_reg   <= q_cmd.panel_x;
            s1_row_reg <= q_cmd.panel_row;
            s1_ovl_reg <= q_cmd.ovl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Overlay color select
    always_comb
    begin
        s1_item.panel_x   = s1_x_reg;
        s1_item.panel_row = s1_row_reg;
        case (s1_ovl_reg)
            pcosd_pkg::OVL_NONE:  s1_item.pixel_color = rdata_reg;
            pcosd_pkg::OVL_WHITE: s1_item.pixel_color = pcosd_pkg::COLOR_WHITE;
            pcosd_pkg::OVL_GREEN: s1_item.pixel_color = pcosd_pkg::COLOR_GREEN;
            pcosd_pkg::OVL_BLACK: s1_item.pixel_color = pcosd_pkg::COLOR_BLACK;
            default:              s1_item.pixel_color = rdata_reg;
        endcase
    end

    // Result queue
    pcosd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (pcosd_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_valid_reg),
        .wr_data (s1_item),
        .rd_en   (pop),
        .rd_data (head_bits),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign head_item   = pcosd_pkg::out_item_t'(head_bits);
    assign panel_x     = head_item.panel_x;
    assign panel_row   = head_item.panel_row;
    assign pixel_color = head_item.pixel_color;

    // Credit check keeps the queue from overflowing; full only gates the write
    logic unused_full;
    assign unused_full = out_full;

endmodule

`default_nettype wire

// ===== design/palette_crop_osd_pixel_stage.sv =====
// ============================================================================
// palette_crop_osd_pixel_stage
// Display pixel stage: palette lookup to RGB565, crop, frame decimation and
// volume bar overlay.
// ============================================================================
//
//  Channel   Signals                                   Transaction when
//  --------  ----------------------------------------  ----------------------
//  request   push, full, req_type, src_x, src_y,       push && !full
//            pixel_index, palette_color, volume_percent
//  result    empty, pop, panel_x, panel_row,           pop && !empty
//            pixel_color
//  config    cfg_we, cfg_wdata (osd_hold_frames)       cfg_we
//
//  One request per clock sustained while full is low; the front updates
//  state and queues a command on the accepting edge, the back reads the
//  palette RAM into a read register and the result then enters the
//  4-entry output queue from that register. The single-port palette RAM
//  (one write or one read a cycle) sets the rate. full rises when the
//  2-entry command queue fills under result back-pressure. Reset clears the
//  control state only; palette entries are undefined until written.
// ============================================================================
`default_nettype none

module palette_crop_osd_pixel_stage #(
    parameter int CROP_LEFT  = 8,
    parameter int OUT_WIDTH  = 240,
    parameter int OUT_HEIGHT = 240,
    parameter int PANEL_TOP  = 40,
    parameter int BAR_HEIGHT = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        src_x,
    input  wire logic [7:0]        src_y,
    input  wire logic [7:0]        pixel_index,
    input  wire logic [15:0]       palette_color,
    input  wire logic signed [7:0] volume_percent,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    // result channel
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             panel_x,
    output logic [8:0]             panel_row,
    output logic [15:0]            pixel_color
);

    localparam int CMD_W     = $bits(pcosd_pkg::cmd_t);
    localparam int CMD_CNT_W = $clog2(pcosd_pkg::CMD_DEPTH + 1);

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    pcosd_pkg::cmd_t      q_wr_cmd;
    logic [CMD_W-1:0]     q_rd_bits;
    logic [CMD_CNT_W-1:0] q_count;
    pcosd_pkg::cmd_t      q_rd_cmd;

    assign full = q_full;

    // Front: classify and update frame / overlay state
    pcosd_front #(
        .CROP_LEFT  (CROP_LEFT),
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT),
        .PANEL_TOP  (PANEL_TOP),
        .BAR_HEIGHT (BAR_HEIGHT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .req_type       (req_type),
        .src_x          (src_x),
        .src_y          (src_y),
        .pixel_index    (pixel_index),
        .palette_color  (palette_color),
        .volume_percent (volume_percent),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_wr_cmd)
    );

    // Command queue between front and back
    pcosd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (pcosd_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_cmd),
        .rd_en   (q_pop),
        .rd_data (q_rd_bits),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    assign q_rd_cmd = pcosd_pkg::cmd_t'(q_rd_bits);

    // Back: palette RAM, overlay select, result queue
    pcosd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (q_rd_cmd),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .panel_x     (panel_x),
        .panel_row   (panel_row),
        .pixel_color (pixel_color)
    );

    // Occupancy of the command queue is not needed at this level
    logic unused_q_count;
    assign unused_q_count = ^q_count;

endmodule

`default_nettype wire
